// ===== sv/dilp_pkg.sv =====
// Shared types and constants for the decimal integer list parser.
// No dependencies; every other file refers to this package by scoped names.
package dilp_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TotalW  = 17;

  // element count saturates here; shown in the low TotalW bits
  localparam int unsigned MaxElements = 65536;
  localparam int unsigned CountW      = $clog2(MaxElements + 1);

  localparam int unsigned Radix = 10;

  localparam logic [DataW-1:0] ChOpen    = 8'h5B; // '['
  localparam logic [DataW-1:0] ChClose   = 8'h5D; // ']'
  localparam logic [DataW-1:0] ChComma   = 8'h2C; // ','
  localparam logic [DataW-1:0] ChHash    = 8'h23; // '#'
  localparam logic [DataW-1:0] ChMinus   = 8'h2D; // '-'
  localparam logic [DataW-1:0] ChPlus    = 8'h2B; // '+'
  localparam logic [DataW-1:0] ChZero    = 8'h30; // '0'
  localparam logic [DataW-1:0] ChNine    = 8'h39; // '9'
  localparam logic [DataW-1:0] ChSpace   = 8'h20;
  localparam logic [DataW-1:0] ChTab     = 8'h09;
  localparam logic [DataW-1:0] ChLf      = 8'h0A;
  localparam logic [DataW-1:0] ChCr      = 8'h0D;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NO_OPEN   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ELEMENT = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [TotalW-1:0]        total;
    logic                     last;
  } result_t;

  // up to two results produced by one byte, in order r0 then r1
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

endpackage

// ===== sv/dilp_if.sv =====
// Valid/ready stream interfaces for the byte input and the result output.
// Depends on dilp_pkg for field widths.
interface dilp_in_if;
  logic                        valid;
  logic                        ready;
  logic [dilp_pkg::DataW-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dilp_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic signed [dilp_pkg::ValueW-1:0]  element_value;
  logic [dilp_pkg::StatusW-1:0]        parse_status;
  logic [dilp_pkg::TotalW-1:0]         element_total;
  logic                                last_result;

  modport source (output valid, result_kind, element_value, parse_status, element_total,
                  last_result, input ready);
  modport sink   (input valid, result_kind, element_value, parse_status, element_total,
                  last_result, output ready);
endinterface

// ===== sv/dilp_parse_core.sv =====
// Parser state and per-byte next-state logic; emits up to two results per byte.
// Depends on dilp_pkg.
module dilp_parse_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [dilp_pkg::DataW-1:0] data_byte_i,
  input  logic                       last_byte_i,
  output dilp_pkg::res_pair_t        pair_o
);

  localparam logic [dilp_pkg::ValueW-1:0] MagPosMax  = 32'h7FFF_FFFF;
  localparam logic [dilp_pkg::ValueW-1:0] MagNegMax  = 32'h8000_0000;
  localparam logic [dilp_pkg::ValueW-1:0] MagStepMax = MagPosMax / dilp_pkg::Radix;
  localparam int unsigned AccW = dilp_pkg::ValueW + 4;

  typedef enum logic [1:0] {PhWait, PhList, PhDone, PhErr} phase_e;

  typedef struct packed {
    logic                          neg;
    logic                          saw;
    logic [dilp_pkg::ValueW-1:0]   mag;
    dilp_pkg::status_e             fault;
  } tok_t;

  function automatic tok_t add_char(tok_t t_in, logic [dilp_pkg::DataW-1:0] c, logic first);
    tok_t                        t;
    logic [dilp_pkg::ValueW-1:0] limit;
    logic [AccW-1:0]             acc;
    t     = t_in;
    limit = t_in.neg ? MagNegMax : MagPosMax;
    acc   = '0;
    if (t.fault != dilp_pkg::ST_OK) begin
      t = t_in;
    end else if (first && (c == dilp_pkg::ChMinus || c == dilp_pkg::ChPlus)) begin
      t.neg = (c == dilp_pkg::ChMinus);
    end else if (c < dilp_pkg::ChZero || c > dilp_pkg::ChNine) begin
      t.fault = dilp_pkg::ST_MALFORMED;
    end else begin
      t.saw = 1'b1;
      if (t.mag > MagStepMax) begin
        t.fault = dilp_pkg::ST_RANGE;
      end else begin
        acc = AccW'(t.mag) * AccW'(dilp_pkg::Radix) + AccW'(c - dilp_pkg::ChZero);
        if (acc > AccW'(limit)) begin
          t.fault = dilp_pkg::ST_RANGE;
        end else begin
          t.mag = acc[dilp_pkg::ValueW-1:0];
        end
      end
    end
    return t;
  endfunction

  phase_e                        phase_q, phase_d;
  logic                          in_comment_q, in_comment_d;
  logic                          tok_active_q, tok_active_d;
  tok_t                          tok_q, tok_d;
  logic                          comma_ok_q, comma_ok_d;
  dilp_pkg::status_e             err_q, err_d;
  logic [dilp_pkg::CountW-1:0]   count_q, count_d;

  always_comb begin : p_next
    logic                       is_space;
    logic                       is_term;
    logic                       close_on_term;
    logic                       close_tok;
    dilp_pkg::status_e          code;
    dilp_pkg::result_t          elem;
    dilp_pkg::result_t          stat;
    logic                       has_elem;
    logic [dilp_pkg::DataW-1:0] c;

    c        = data_byte_i;
    is_space = (c == dilp_pkg::ChSpace) || (c == dilp_pkg::ChTab) ||
               (c == dilp_pkg::ChLf) || (c == dilp_pkg::ChCr);
    is_term  = is_space || (c == dilp_pkg::ChComma) || (c == dilp_pkg::ChClose) ||
               (c == dilp_pkg::ChHash);
    close_on_term = 1'b0;
    close_tok     = 1'b0;
    code          = dilp_pkg::ST_OK;
    has_elem      = 1'b0;
    elem          = '0;
    stat          = '0;

    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    tok_active_d = tok_active_q;
    tok_d        = tok_q;
    comma_ok_d   = comma_ok_q;
    err_d        = err_q;
    count_d      = count_q;
    pair_o       = '0;

    if (go_i) begin
      if (phase_q == PhDone || phase_q == PhErr) begin
        phase_d = phase_q; // bytes ignored until the last one
      end else if (in_comment_q) begin
        if (c == dilp_pkg::ChLf || c == dilp_pkg::ChCr) begin
          in_comment_d = 1'b0;
        end
      end else if (phase_q == PhWait) begin
        if (c == dilp_pkg::ChHash) begin
          in_comment_d = 1'b1;
        end else if (c == dilp_pkg::ChOpen) begin
          phase_d = PhList;
        end else if (!is_space) begin
          phase_d = PhErr;
          err_d   = dilp_pkg::ST_NO_OPEN;
        end
      end else if (tok_active_q) begin
        if (is_term) begin
          // token closes first; the terminator itself acts afterward
          close_on_term = 1'b1;
          if (c == dilp_pkg::ChHash) begin
            in_comment_d = 1'b1;
          end else if (c == dilp_pkg::ChClose) begin
            phase_d = PhDone;
          end
        end else begin
          tok_d = add_char(tok_q, c, 1'b0);
        end
      end else begin
        if (c == dilp_pkg::ChHash) begin
          in_comment_d = 1'b1;
        end else if (c == dilp_pkg::ChClose) begin
          phase_d = PhDone;
        end else if (c == dilp_pkg::ChComma) begin
          if (comma_ok_q) begin
            comma_ok_d = 1'b0;
          end else begin
            phase_d = PhErr;
            err_d   = dilp_pkg::ST_MALFORMED;
          end
        end else if (!is_space) begin
          tok_active_d = 1'b1;
          comma_ok_d   = 1'b0;
          tok_d        = add_char('{neg: 1'b0, saw: 1'b0, mag: '0, fault: dilp_pkg::ST_OK},
                                  c, 1'b1);
        end
      end

      // a text that ends inside a token closes it too
      close_tok = close_on_term || (last_byte_i && phase_d == PhList && tok_active_d);

      if (close_tok) begin
        tok_active_d = 1'b0;
        if (tok_d.fault != dilp_pkg::ST_OK) begin
          code = tok_d.fault;
        end else if (!tok_d.saw) begin
          code = dilp_pkg::ST_MALFORMED;
        end else begin
          code = dilp_pkg::ST_OK;
        end
        if (code != dilp_pkg::ST_OK) begin
          phase_d      = PhErr;
          err_d        = code;
          in_comment_d = 1'b0;
        end else begin
          if (count_q < dilp_pkg::CountW'(dilp_pkg::MaxElements)) begin
            count_d = count_q + dilp_pkg::CountW'(1);
          end
          has_elem    = 1'b1;
          elem.kind   = dilp_pkg::KIND_ELEMENT;
          elem.value  = tok_d.neg ? $signed(-tok_d.mag) : $signed(tok_d.mag);
          elem.status = dilp_pkg::ST_OK;
          elem.total  = dilp_pkg::TotalW'(count_d);
          elem.last   = !last_byte_i;
          comma_ok_d  = !(close_on_term && c == dilp_pkg::ChComma);
        end
      end

      if (last_byte_i) begin
        stat.kind   = dilp_pkg::KIND_STATUS;
        stat.value  = '0;
        stat.status = (phase_d == PhWait) ? dilp_pkg::ST_NO_OPEN : err_d;
        stat.total  = dilp_pkg::TotalW'(count_d);
        stat.last   = 1'b1;
        phase_d      = PhWait;
        in_comment_d = 1'b0;
        tok_active_d = 1'b0;
        tok_d        = '{neg: 1'b0, saw: 1'b0, mag: '0, fault: dilp_pkg::ST_OK};
        comma_ok_d   = 1'b0;
        err_d        = dilp_pkg::ST_OK;
        count_d      = '0;
      end

      if (has_elem) begin
        pair_o.r0 = elem;
        pair_o.r1 = stat;
        pair_o.n  = last_byte_i ? 2'd2 : 2'd1;
      end else if (last_byte_i) begin
        pair_o.r0 = stat;
        pair_o.n  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhWait;
      in_comment_q <= 1'b0;
      tok_active_q <= 1'b0;
      tok_q        <= '{neg: 1'b0, saw: 1'b0, mag: '0, fault: dilp_pkg::ST_OK};
      comma_ok_q   <= 1'b0;
      err_q        <= dilp_pkg::ST_OK;
      count_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      tok_active_q <= tok_active_d;
      tok_q        <= tok_d;
      comma_ok_q   <= comma_ok_d;
      err_q        <= err_d;
      count_q      <= count_d;
    end
  end

endmodule

// ===== sv/dilp_result_fifo.sv =====
// Four-entry result queue taking up to two results per cycle, one out per beat.
// Depends on dilp_pkg and dilp_out_if.
module dilp_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dilp_pkg::res_pair_t pair_i,
  output logic                room_o,
  dilp_out_if.source          out_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dilp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;
  dilp_pkg::result_t head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (cnt_q <= CntW'(Depth - 2));
  assign head   = mem_q[rd_ptr_q];

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.result_kind   = head.kind;
  assign out_o.element_value = head.value;
  assign out_o.parse_status  = head.status;
  assign out_o.element_total = head.total;
  assign out_o.last_result   = head.last;

  always_ff @(posedge clk_i) begin
    if (pair_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.r0;
    end
    if (pair_i.n == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= pair_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(pair_i.n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(pair_i.n) - CntW'(pop);
    end
  end

endmodule

// ===== sv/decimal_int_list_parser_unit.sv =====
// Bracketed decimal integer list parser. Takes one text byte per beat and
// returns each completed element as a signed 32-bit value, then a status and
// element count on the byte marked last. One byte is accepted every cycle
// while the result queue has room; a byte passes an input register, then the
// parse logic, and its results are written into the result queue, from which
// they are presented at the output. A last byte that also closes a token
// yields two results and so takes two output beats. Results go through a
// four-entry queue; input stalls only when that queue has fewer than two free
// entries, which happens when the consumer holds ready low.
// Depends on dilp_pkg, dilp_if, dilp_parse_core and dilp_result_fifo.
module decimal_int_list_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dilp_in_if.sink    in_i,
  dilp_out_if.source out_o
);

  logic                       s1_valid_q;
  logic [dilp_pkg::DataW-1:0] s1_byte_q;
  logic                       s1_last_q;
  logic                       room;
  logic                       advance;
  logic                       accept;
  dilp_pkg::res_pair_t        pair;

  assign advance    = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || room;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  dilp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (advance),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .pair_o      (pair)
  );

  dilp_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair),
    .room_o (room),
    .out_o  (out_o)
  );

  // a last byte always produces a status result
  a_last_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |-> (pair.n != 2'd0))
    else $error("last byte produced no result");

  // two results in one beat are always an element followed by the status
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair.n == 2'd2) |-> (pair.r0.kind == dilp_pkg::KIND_ELEMENT &&
                          pair.r1.kind == dilp_pkg::KIND_STATUS && pair.r1.last))
    else $error("bad result pair");

  // nothing is produced without a byte moving into the parser
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> (pair.n == 2'd0))
    else $error("result without a byte");

  // a status result always ends its byte's results
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == dilp_pkg::KIND_STATUS) |-> out_o.last_result)
    else $error("status not marked last");

endmodule
